// ----- rtl/core/mirq_pkg.sv -----
// Package with the codes, constants and transaction types of the IRQ counter and tone generator.
`timescale 1ns / 1ps
`default_nettype none

package mirq_pkg;

   // Number of tone channels that are built.
   localparam int NUM_TONES = 3;

   // Item kinds.
   typedef enum logic [1:0] {
      OP_BUS_WRITE  = 2'd0,
      OP_CPU_TICK   = 2'd1,
      OP_AUDIO_TICK = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   // Bus windows picked by address bits 15-13.
   localparam logic [2:0] WIN_CMD_INDEX = 3'b100;
   localparam logic [2:0] WIN_CMD_DATA  = 3'b101;
   localparam logic [2:0] WIN_SND_INDEX = 3'b110;
   localparam logic [2:0] WIN_SND_DATA  = 3'b111;

   // Command targets.
   localparam logic [3:0] CMD_IRQ_CONTROL = 4'd13;
   localparam logic [3:0] CMD_COUNT_LOW   = 4'd14;
   localparam logic [3:0] CMD_COUNT_HIGH  = 4'd15;

   // Sound targets.
   localparam logic [3:0] SND_PERIOD_LAST = 4'd5;
   localparam logic [3:0] SND_DISABLE     = 4'd7;
   localparam logic [3:0] SND_VOLUME_A    = 4'd8;
   localparam logic [3:0] SND_VOLUME_C    = 4'd10;

   // IRQ control bits.
   localparam int IRQ_CTRL_COUNT_BIT  = 7;
   localparam int IRQ_CTRL_ENABLE_BIT = 0;

   // Step counter bit that gates the tone output.
   localparam int STEP_GATE_BIT = 4;

   // Input transaction.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic       irq_line;
      logic [3:0] tone_a_level;
      logic [3:0] tone_b_level;
      logic [3:0] tone_c_level;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/mapper_irq_counter_and_tone_gen.sv -----
// Each result is written into the result buffer when its transaction is accepted.
// Throughput: one transaction per cycle; a two-entry result buffer keeps
// req_ready high while one result waits, and it drops only when both are full.
// Reset (synchronous, active high) clears all IRQ and tone state, sets each
// tone timer to one and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module mapper_irq_counter_and_tone_gen (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mirq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mirq_pkg::rsp_type      rsp_data
);

   localparam int NT = mirq_pkg::NUM_TONES;

   // State registers and their next values.
   logic [3:0]  command_index_ff, command_index_in;
   logic [7:0]  irq_control_ff, irq_control_in;
   logic [15:0] irq_count_ff, irq_count_in;
   logic        irq_pending_ff, irq_pending_in;
   logic [3:0]  sound_index_ff, sound_index_in;
   logic [11:0] tone_period_ff [NT];
   logic [11:0] tone_period_in [NT];
   logic [3:0]  tone_volume_ff [NT];
   logic [3:0]  tone_volume_in [NT];
   logic        tone_disabled_ff [NT];
   logic        tone_disabled_in [NT];
   logic [4:0]  tone_step_ff [NT];
   logic [4:0]  tone_step_in [NT];
   logic [12:0] tone_timer_ff [NT];
   logic [12:0] tone_timer_in [NT];

   // Result buffer.
   mirq_pkg::rsp_type head_ff, head_in;
   mirq_pkg::rsp_type tail_ff, tail_in;
   logic [1:0]        count_ff, count_in;
   mirq_pkg::rsp_type result;
   logic [3:0]        level [3];

   logic       accept;
   logic       drain;
   logic [2:0] window;
   logic [3:0] sidx;
   logic [7:0] data;
   logic [12:0] timer_dec;

   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign accept    = req_valid && req_ready;
   assign drain     = rsp_valid && rsp_ready;
   assign window    = req_data.bus_address[15:13];
   assign sidx      = sound_index_ff;
   assign data      = req_data.bus_data;

   // Next state for one accepted transaction.
   always_comb begin
      command_index_in = command_index_ff;
      irq_control_in   = irq_control_ff;
      irq_count_in     = irq_count_ff;
      irq_pending_in   = irq_pending_ff;
      sound_index_in   = sound_index_ff;
      timer_dec        = '0;
      for (int ch = 0; ch < NT; ch++) begin
         tone_period_in[ch]   = tone_period_ff[ch];
         tone_volume_in[ch]   = tone_volume_ff[ch];
         tone_disabled_in[ch] = tone_disabled_ff[ch];
         tone_step_in[ch]     = tone_step_ff[ch];
         tone_timer_in[ch]    = tone_timer_ff[ch];
      end
      unique case (mirq_pkg::opcode_type'(req_data.opcode))
         mirq_pkg::OP_BUS_WRITE: begin
            unique case (window)
               mirq_pkg::WIN_CMD_INDEX: command_index_in = data[3:0];
               mirq_pkg::WIN_CMD_DATA: begin
                  if (command_index_ff == mirq_pkg::CMD_IRQ_CONTROL) begin
                     irq_control_in = data;
                     irq_pending_in = 1'b0;
                  end else if (command_index_ff == mirq_pkg::CMD_COUNT_LOW) begin
                     irq_count_in = {irq_count_ff[15:8], data};
                  end else if (command_index_ff == mirq_pkg::CMD_COUNT_HIGH) begin
                     irq_count_in = {data, irq_count_ff[7:0]};
                  end
               end
               mirq_pkg::WIN_SND_INDEX: sound_index_in = data[3:0];
               mirq_pkg::WIN_SND_DATA: begin
                  for (int ch = 0; ch < NT; ch++) begin
                     if (sidx <= mirq_pkg::SND_PERIOD_LAST && sidx[2:1] == 2'(ch)) begin
                        if (sidx[0]) begin
                           tone_period_in[ch] = {data[3:0], tone_period_ff[ch][7:0]};
                        end else begin
                           tone_period_in[ch] = {tone_period_ff[ch][11:8], data};
                        end
                     end
                     if (sidx == mirq_pkg::SND_DISABLE) begin
                        tone_disabled_in[ch] = data[ch];
                     end
                     if (sidx >= mirq_pkg::SND_VOLUME_A && sidx <= mirq_pkg::SND_VOLUME_C
                         && sidx[1:0] == 2'(ch)) begin
                        tone_volume_in[ch] = data[3:0];
                     end
                  end
               end
               default: ;
            endcase
         end
         mirq_pkg::OP_CPU_TICK: begin
            if (irq_control_ff[mirq_pkg::IRQ_CTRL_COUNT_BIT]) begin
               irq_count_in = irq_count_ff - 16'd1;
               if (irq_count_in == 16'd0 && irq_control_ff[mirq_pkg::IRQ_CTRL_ENABLE_BIT]) begin
                  irq_pending_in = 1'b1;
               end
            end
         end
         mirq_pkg::OP_AUDIO_TICK: begin
            for (int ch = 0; ch < NT; ch++) begin
               timer_dec = tone_timer_ff[ch] - 13'd1;
               if (timer_dec == 13'd0) begin
                  tone_step_in[ch]  = tone_step_ff[ch] + 5'd1;
                  tone_timer_in[ch] = {1'b0, tone_period_ff[ch]} + 13'd1;
               end else begin
                  tone_timer_in[ch] = timer_dec;
               end
            end
         end
         default: ;
      endcase
   end

   // Channel levels from the state after the transaction.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         level[ch] = 4'd0;
      end
      for (int ch = 0; ch < NT; ch++) begin
         if (!tone_disabled_in[ch] && tone_step_in[ch][mirq_pkg::STEP_GATE_BIT]) begin
            level[ch] = tone_volume_in[ch];
         end
      end
      result.irq_line     = irq_pending_in;
      result.tone_a_level = level[0];
      result.tone_b_level = level[1];
      result.tone_c_level = level[2];
   end

   // Result buffer: head is shown on the port, tail catches one more result.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({accept, drain})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = result;
            end else begin
               tail_in = result;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = result;
            end else begin
               head_in = tail_ff;
               tail_in = result;
            end
         end
         default: ;
      endcase
   end

   // State update.
   always_ff @(posedge clock) begin
      if (reset) begin
         command_index_ff <= '0;
         irq_control_ff   <= '0;
         irq_count_ff     <= '0;
         irq_pending_ff   <= 1'b0;
         sound_index_ff   <= '0;
         for (int ch = 0; ch < NT; ch++) begin
            tone_period_ff[ch]   <= '0;
            tone_volume_ff[ch]   <= '0;
            tone_disabled_ff[ch] <= 1'b0;
            tone_step_ff[ch]     <= '0;
            tone_timer_ff[ch]    <= 13'd1;
         end
      end else if (accept) begin
         command_index_ff <= command_index_in;
         irq_control_ff   <= irq_control_in;
         irq_count_ff     <= irq_count_in;
         irq_pending_ff   <= irq_pending_in;
         sound_index_ff   <= sound_index_in;
         for (int ch = 0; ch < NT; ch++) begin
            tone_period_ff[ch]   <= tone_period_in[ch];
            tone_volume_ff[ch]   <= tone_volume_in[ch];
            tone_disabled_ff[ch] <= tone_disabled_in[ch];
            tone_step_ff[ch]     <= tone_step_in[ch];
            tone_timer_ff[ch]    <= tone_timer_in[ch];
         end
      end
   end

   // Buffer control and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // The buffer never holds more than two results.
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("result buffer overflow");

   // A pending IRQ is raised only by an accepted CPU tick.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(irq_pending_ff) |->
         $past(accept) && $past(req_data.opcode) == mirq_pkg::OP_CPU_TICK)
      else $error("IRQ raised without a CPU tick");

   // The IRQ count holds while no transaction is accepted.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(accept) |-> $stable(irq_count_ff))
      else $error("IRQ count changed without a transaction");

   // The buffer fills by one on an accept with no drain.
   assert property (@(posedge clock) disable iff (reset)
      accept && !drain |=> count_ff == $past(count_ff) + 2'd1)
      else $error("result buffer count slip");

endmodule

`default_nettype wire
